// ----- src/hsv2rgb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the 8-bit HSV to RGB converter: payload structs, sector codes
// and the constants of the fixed-point datapath. No dependencies.
package hsv2rgb_pkg;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_pix_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pix_t;

    typedef enum logic [2:0] {
        SECT_RED_UP   = 3'd0,
        SECT_GRN_MAX  = 3'd1,
        SECT_BLU_UP   = 3'd2,
        SECT_BLU_MAX  = 3'd3,
        SECT_RED_RISE = 3'd4,
        SECT_RED_MAX  = 3'd5
    } sector_t;

    // Sector boundaries on the hue: first hue with floor(2h/85) >= 1..5
    localparam logic [7:0] HUE_EDGE_1 = 8'd43;
    localparam logic [7:0] HUE_EDGE_2 = 8'd85;
    localparam logic [7:0] HUE_EDGE_3 = 8'd128;
    localparam logic [7:0] HUE_EDGE_4 = 8'd170;
    localparam logic [7:0] HUE_EDGE_5 = 8'd213;

    localparam logic [8:0] TWO_SPAN   = 9'd170;
    localparam logic [8:0] FOUR_SPAN  = 9'd340;
    localparam logic [7:0] RAMP_MAX   = 8'd85;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Numerators reach 255 * 21675, i.e. 23 bits
    localparam int unsigned NUM_W     = 23;
    localparam int unsigned DIV_DEN_W = 15;
    localparam logic [DIV_DEN_W-1:0] DIV_DEN = 15'd21675;

    // Reciprocal of the divisor, rounded down; estimate is at most one short
    localparam int unsigned DIV_SHIFT = 32;
    localparam int unsigned DIV_MUL_W = 18;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'((64'd1 << DIV_SHIFT) / 64'd21675);
    localparam int unsigned PROD_W    = NUM_W + DIV_MUL_W;

endpackage

// ----- src/hsv_to_rgb_8bit.sv -----
`timescale 1ns / 1ps
// Top level of the 8-bit HSV to RGB converter: four-stage pipeline.
// Depends on hsv2rgb_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carry one HSV colour per transaction; m_valid/
//   m_ready/m_data return the matching RGB colour, in order, one per input.
//   m_valid rises once the colour has passed the stage 1, 2, 3 and 4 registers,
//   and the result is held there until the receiver takes it. One colour
//   is accepted every cycle while the receiver takes results; the multipliers
//   are spread over all four stages, so no stage limits the rate.
//   Stage 1: hue sector, ramp weight, v*(255-s) and the ramp numerator term.
//   Stage 2: full numerators of the minimum and ramp channels.
//   Stage 3: quotient estimates by multiplication with the reciprocal.
//   Stage 4: one-step correction, sector selection, output register.
//   When m_ready is low the pipeline closes up its bubbles and then holds;
//   s_ready drops only once every stage is occupied. Nothing is lost or
//   repeated across a stall.
//   Synchronous active-low reset clears all stage valid bits; payload
//   registers are not reset.
module hsv_to_rgb_8bit
    import hsv2rgb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hsv_pix_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rgb_pix_t m_data
);

    // ---------------- stage handshake ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || m_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1 ----------------
    logic [8:0]           twoh;
    logic [8:0]           rem_wide;
    logic [7:0]           rem;
    logic [6:0]           ramp_t;
    logic [7:0]           sbar;
    sector_t              sect_next;
    logic [15:0]          a_next;
    logic [DIV_DEN_W-1:0] b_next;

    sector_t              sect1_reg;
    logic                 grey1_reg;
    logic [7:0]           v1d_reg;
    logic [15:0]          a1_reg;
    logic [DIV_DEN_W-1:0] b1_reg;

    always_comb begin
        twoh = {s_data.hue, 1'b0};
        priority if (twoh >= FOUR_SPAN) begin
            rem_wide = twoh - FOUR_SPAN;
        end else if (twoh >= TWO_SPAN) begin
            rem_wide = twoh - TWO_SPAN;
        end else begin
            rem_wide = twoh;
        end
        rem = rem_wide[7:0];
        // ramp rises over the first half of a sector pair and falls over the second
        if (rem < RAMP_MAX) begin
            ramp_t = rem[6:0];
        end else begin
            ramp_t = 7'(TWO_SPAN[7:0] - rem);
        end

        priority if (s_data.hue >= HUE_EDGE_5) begin
            sect_next = SECT_RED_MAX;
        end else if (s_data.hue >= HUE_EDGE_4) begin
            sect_next = SECT_RED_RISE;
        end else if (s_data.hue >= HUE_EDGE_3) begin
            sect_next = SECT_BLU_MAX;
        end else if (s_data.hue >= HUE_EDGE_2) begin
            sect_next = SECT_BLU_UP;
        end else if (s_data.hue >= HUE_EDGE_1) begin
            sect_next = SECT_GRN_MAX;
        end else begin
            sect_next = SECT_RED_UP;
        end

        sbar   = FULL_SCALE - s_data.saturation;
        a_next = 16'(s_data.brightness) * 16'(sbar);
        b_next = DIV_DEN_W'(DIV_DEN_W'(RAMP_MAX) * DIV_DEN_W'(sbar))
               + DIV_DEN_W'(DIV_DEN_W'(s_data.saturation) * DIV_DEN_W'(ramp_t));
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            sect1_reg <= sect_next;
            grey1_reg <= (s_data.saturation == 8'd0);
            v1d_reg   <= s_data.brightness;
            a1_reg    <= a_next;
            b1_reg    <= b_next;
        end
    end

    // ---------------- stage 2 ----------------
    sector_t          sect2_reg;
    logic             grey2_reg;
    logic [7:0]       v2d_reg;
    logic [NUM_W-1:0] nlo2_reg;
    logic [NUM_W-1:0] nmid2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            sect2_reg <= sect1_reg;
            grey2_reg <= grey1_reg;
            v2d_reg   <= v1d_reg;
            nlo2_reg  <= NUM_W'(a1_reg) * NUM_W'(RAMP_MAX);
            nmid2_reg <= NUM_W'(v1d_reg) * NUM_W'(b1_reg);
        end
    end

    // ---------------- stage 3 ----------------
    logic [PROD_W-1:0] plo;
    logic [PROD_W-1:0] pmid;

    sector_t          sect3_reg;
    logic             grey3_reg;
    logic [7:0]       v3d_reg;
    logic [NUM_W-1:0] nlo3_reg;
    logic [NUM_W-1:0] nmid3_reg;
    logic [8:0]       qlo3_reg;
    logic [8:0]       qmid3_reg;

    assign plo  = PROD_W'(nlo2_reg)  * PROD_W'(DIV_MUL);
    assign pmid = PROD_W'(nmid2_reg) * PROD_W'(DIV_MUL);

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            sect3_reg <= sect2_reg;
            grey3_reg <= grey2_reg;
            v3d_reg   <= v2d_reg;
            nlo3_reg  <= nlo2_reg;
            nmid3_reg <= nmid2_reg;
            qlo3_reg  <= plo[DIV_SHIFT+8:DIV_SHIFT];
            qmid3_reg <= pmid[DIV_SHIFT+8:DIV_SHIFT];
        end
    end

    // ---------------- stage 4 ----------------
    logic [NUM_W:0] rlo;
    logic [NUM_W:0] rmid;
    logic [7:0]     lo;
    logic [7:0]     mid;
    logic [7:0]     hi;
    rgb_pix_t       rgb_next;
    rgb_pix_t       rgb_reg;

    always_comb begin
        // estimate is exact or one short: fix up from the remainder
        rlo  = (NUM_W+1)'(nlo3_reg)  - (NUM_W+1)'((NUM_W+1)'(qlo3_reg)  * (NUM_W+1)'(DIV_DEN));
        rmid = (NUM_W+1)'(nmid3_reg) - (NUM_W+1)'((NUM_W+1)'(qmid3_reg) * (NUM_W+1)'(DIV_DEN));
        lo  = (rlo  >= (NUM_W+1)'(DIV_DEN)) ? 8'(qlo3_reg  + 9'd1) : qlo3_reg[7:0];
        mid = (rmid >= (NUM_W+1)'(DIV_DEN)) ? 8'(qmid3_reg + 9'd1) : qmid3_reg[7:0];
        hi  = v3d_reg;

        if (grey3_reg) begin
            rgb_next = '{red: hi, green: hi, blue: hi};
        end else begin
            unique case (sect3_reg)
                SECT_RED_UP:   rgb_next = '{red: hi,  green: mid, blue: lo};
                SECT_GRN_MAX:  rgb_next = '{red: mid, green: hi,  blue: lo};
                SECT_BLU_UP:   rgb_next = '{red: lo,  green: hi,  blue: mid};
                SECT_BLU_MAX:  rgb_next = '{red: lo,  green: mid, blue: hi};
                SECT_RED_RISE: rgb_next = '{red: mid, green: lo,  blue: hi};
                default:       rgb_next = '{red: hi,  green: lo,  blue: mid};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            rgb_reg <= rgb_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_data  = rgb_reg;

    // ---------------- assertions ----------------
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid set after reset");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && m_valid && !m_ready))
        else $error("input stalled while the pipeline has room");

    a_quot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (!qlo3_reg[8] && !qmid3_reg[8]))
        else $error("quotient estimate exceeds eight bits");

    a_channel_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !grey3_reg) |-> (lo <= mid && mid <= hi))
        else $error("minimum, ramp and maximum out of order");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_8bit: drives HSV colours through the
// valid/ready input channel and checks every RGB result against an integer
// predictor held in a scoreboard class. Depends on hsv2rgb_pkg and the RTL.
module testbench;
    import hsv2rgb_pkg::*;

    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned RANDOM_ITEMS = 310;

    class colour_scoreboard;
        rgb_pix_t    expected_q[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        // Exact integer HSV to RGB, truncating each channel toward zero
        function rgb_pix_t predict_rgb(hsv_pix_t px);
            int unsigned h, s, v, twoh, sect_num, rem, ramp, base, lo, mid;
            sector_t     sect;
            rgb_pix_t    c;
            h = 32'(px.hue);
            s = 32'(px.saturation);
            v = 32'(px.brightness);
            if (s == 0) begin
                c.red   = v[7:0];
                c.green = v[7:0];
                c.blue  = v[7:0];
                return c;
            end
            twoh     = 2 * h;
            sect_num = twoh / RAMP_MAX;
            // hue 255 works out to the seventh sector; fold it into the last
            if (sect_num > 5)
                sect_num = 5;
            rem  = twoh % TWO_SPAN;
            ramp = (rem >= RAMP_MAX) ? (2 * RAMP_MAX - rem) : rem;
            base = v * (FULL_SCALE - s) * RAMP_MAX;
            lo   = base / DIV_DEN;
            mid  = (base + v * s * ramp) / DIV_DEN;
            sect = sector_t'(sect_num[2:0]);
            case (sect)
                SECT_RED_UP: begin
                    c = {v[7:0], mid[7:0], lo[7:0]};
                end
                SECT_GRN_MAX: begin
                    c = {mid[7:0], v[7:0], lo[7:0]};
                end
                SECT_BLU_UP: begin
                    c = {lo[7:0], v[7:0], mid[7:0]};
                end
                SECT_BLU_MAX: begin
                    c = {lo[7:0], mid[7:0], v[7:0]};
                end
                SECT_RED_RISE: begin
                    c = {mid[7:0], lo[7:0], v[7:0]};
                end
                default: begin
                    c = {v[7:0], lo[7:0], mid[7:0]};
                end
            endcase
            return c;
        endfunction

        function void note_colour(hsv_pix_t px);
            expected_q.push_back(predict_rgb(px));
        endfunction

        function void check_colour(rgb_pix_t got);
            rgb_pix_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %h arrived with nothing expected", got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: rgb expected %h/%h/%h, got %h/%h/%h",
                             want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hsv_pix_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rgb_pix_t m_data;

    int unsigned      src_idle_pct = 0;
    int unsigned      sink_idle_pct = 0;
    int unsigned      stall_cycles = 0;
    int unsigned      colours_sent = 0;
    colour_scoreboard colour_sb = new();

    hsv_to_rgb_8bit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Observe both channels at the edge on which each transaction completes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                colour_sb.note_colour(s_data);
            if (m_valid && m_ready)
                colour_sb.check_colour(m_data);
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles + 1 >= STALL_LIMIT) begin
                    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Called just after a rising edge; returns just after the accepting edge
    task automatic send_colour(input logic [7:0] h, input logic [7:0] s,
                               input logic [7:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{hue: h, saturation: s, brightness: v};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        colours_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (colour_sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_corner_hue();
        logic [7:0] edges[12] = '{8'd0, 8'd42, HUE_EDGE_1, 8'd84, HUE_EDGE_2, 8'd127,
                                  HUE_EDGE_3, 8'd169, HUE_EDGE_4, 8'd212, HUE_EDGE_5,
                                  8'd255};
        return edges[4'($urandom_range(11))];
    endfunction

    function automatic logic [7:0] pick_corner_level();
        logic [7:0] levels[5] = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
        return levels[3'($urandom_range(4))];
    endfunction

    task automatic send_random_colours(input int unsigned count);
        logic [7:0] h, s, v;
        for (int unsigned n = 0; n < count; n++) begin
            h = 8'($urandom_range(255));
            s = 8'($urandom_range(255));
            v = 8'($urandom_range(255));
            // bias a share of items onto sector edges and level extremes
            if ($urandom_range(7) == 0)
                h = pick_corner_hue();
            if ($urandom_range(7) == 0)
                s = pick_corner_level();
            if ($urandom_range(7) == 0)
                v = pick_corner_level();
            send_colour(h, s, v);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero saturation, full saturation, sector edges, hue 255
        send_colour(8'd0,   8'd0,   8'd0);
        send_colour(8'd100, 8'd0,   8'd255);
        send_colour(8'd255, 8'd0,   8'd77);
        send_colour(8'd0,   8'd255, 8'd255);
        send_colour(8'd255, 8'd255, 8'd255);
        send_colour(8'd255, 8'd1,   8'd255);
        send_colour(8'd255, 8'd128, 8'd200);
        send_colour(8'd42,  8'd255, 8'd255);
        send_colour(HUE_EDGE_1, 8'd255, 8'd255);
        send_colour(8'd84,  8'd255, 8'd255);
        send_colour(HUE_EDGE_2, 8'd255, 8'd255);
        send_colour(8'd127, 8'd255, 8'd255);
        send_colour(HUE_EDGE_3, 8'd255, 8'd255);
        send_colour(8'd169, 8'd255, 8'd255);
        send_colour(HUE_EDGE_4, 8'd255, 8'd255);
        send_colour(8'd212, 8'd255, 8'd255);
        send_colour(HUE_EDGE_5, 8'd255, 8'd255);
        send_colour(8'd21,  8'd1,   8'd255);
        send_colour(8'd64,  8'd254, 8'd1);
        send_colour(8'd150, 8'd170, 8'd0);
        send_colour(8'd190, 8'd85,  8'd254);
        send_colour(8'd230, 8'd200, 8'd128);
        wait_results_drained();

        src_idle_pct  = 20;
        sink_idle_pct <= 46;
        send_random_colours(RANDOM_ITEMS);
        // hold off the sender until the pipeline has emptied
        wait_results_drained();

        src_idle_pct  = 46;
        sink_idle_pct <= 20;
        send_random_colours(RANDOM_ITEMS);
        wait_results_drained();

        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        send_random_colours(RANDOM_ITEMS);
        s_valid <= 1'b0;

        while (colour_sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d colours (sector edges, grey, hue 255, random), checked %0d",
                 colours_sent, colour_sb.checked);
        $display("Handshake profiles: slow receiver, slow sender, full rate; %0d mismatches",
                 colour_sb.mismatches);
        if (colour_sb.mismatches == 0 && colour_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
